>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ICDF_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define ICDF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/icdf_pkg.sv
// Widths, latencies and coefficient tables of the inverse normal CDF pipeline
`default_nettype none

package icdf_pkg;

    localparam int U_W      = 32;
    localparam int OUT_W    = 32;
    localparam int Q_FRAC   = 28;

    // pipeline depth from the sample register to the final select
    localparam int PIPE_LAT     = 71;
    localparam int CEN_CORE_LAT = 39;
    localparam int CEN_PAD      = PIPE_LAT - CEN_CORE_LAT;

    localparam int LOG_IN_W = 35;
    localparam int LOG_W    = 34;
    localparam int POLY_W   = 36;
    localparam int ACC_W    = 36;
    localparam int DEN_W    = 36;
    localparam int QUO_W    = 32;
    localparam int TAIL_ORD = 8;

    localparam logic [U_W-1:0]    CENTRAL_LIMIT = 32'd1803886265;
    localparam logic [U_W-1:0]    U_HALF        = 32'h8000_0000;
    localparam logic [29:0]       LN2_Q30       = 30'd744261118;
    localparam logic [63:0]       RND_Q30       = 64'd1 << 29;
    localparam logic [LOG_W-1:0]  TAIL_T0       = LOG_W'(64'd32 << Q_FRAC);
    localparam logic [LOG_W-1:0]  LG_OFF        = LOG_W'(64'd28 << Q_FRAC);
    localparam logic signed [POLY_W-1:0] ONE_Q28 = 36'sd268435456;
    localparam logic [OUT_W-1:0]  MAG_MAX       = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0]  NORM_MIN      = 32'h8000_0000;

    // decimal coefficients scaled by 1e11 to Q28, rounded to nearest
    localparam longint unsigned QA_MUL = 64'd131072;
    localparam longint unsigned QA_RND = 64'd24414062;
    localparam longint unsigned QA_DIV = 64'd48828125;
    localparam longint unsigned A0_M = (64'd250662823884  * QA_MUL + QA_RND) / QA_DIV;
    localparam longint unsigned A1_M = (64'd1861500062529 * QA_MUL + QA_RND) / QA_DIV;
    localparam longint unsigned A2_M = (64'd4139119773534 * QA_MUL + QA_RND) / QA_DIV;
    localparam longint unsigned A3_M = (64'd2544106049637 * QA_MUL + QA_RND) / QA_DIV;
    localparam longint unsigned B0_M = (64'd847351093090  * QA_MUL + QA_RND) / QA_DIV;
    localparam longint unsigned B1_M = (64'd2308336743743 * QA_MUL + QA_RND) / QA_DIV;
    localparam longint unsigned B2_M = (64'd2106224101826 * QA_MUL + QA_RND) / QA_DIV;
    localparam longint unsigned B3_M = (64'd313082909833  * QA_MUL + QA_RND) / QA_DIV;

    localparam logic signed [POLY_W-1:0] NUM_A [4] = '{
        POLY_W'(A0_M), -POLY_W'(A1_M), POLY_W'(A2_M), -POLY_W'(A3_M)
    };
    localparam logic signed [POLY_W-1:0] DEN_B [4] = '{
        -POLY_W'(B0_M), POLY_W'(B1_M), -POLY_W'(B2_M), POLY_W'(B3_M)
    };

    // 12-decimal coefficients scaled by 1e12 to Q32
    localparam longint unsigned QC_MUL = 64'd1048576;
    localparam longint unsigned QC_RND = 64'd122070312;
    localparam longint unsigned QC_DIV = 64'd244140625;
    localparam logic [ACC_W-1:0] TAIL_C [TAIL_ORD+1] = '{
        ACC_W'((64'd337475482273 * QC_MUL + QC_RND) / QC_DIV),
        ACC_W'((64'd976169019092 * QC_MUL + QC_RND) / QC_DIV),
        ACC_W'((64'd160797971492 * QC_MUL + QC_RND) / QC_DIV),
        ACC_W'((64'd27643881033  * QC_MUL + QC_RND) / QC_DIV),
        ACC_W'((64'd3840572937   * QC_MUL + QC_RND) / QC_DIV),
        ACC_W'((64'd395189651    * QC_MUL + QC_RND) / QC_DIV),
        ACC_W'((64'd32176788     * QC_MUL + QC_RND) / QC_DIV),
        ACC_W'((64'd288817       * QC_MUL + QC_RND) / QC_DIV),
        ACC_W'((64'd396032       * QC_MUL + QC_RND) / QC_DIV)
    };

endpackage

`default_nettype wire

>>> rtl/icdf_in_if.sv
// Input channel: uniform sample beats
`default_nettype none

interface icdf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] uniform_in;

    modport source (output valid, output uniform_in, input ready);
    modport sink   (input valid, input uniform_in, output ready);
endinterface

`default_nettype wire

>>> rtl/icdf_out_if.sv
// Output channel: normal deviate beats
`default_nettype none

interface icdf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] normal_out;
    logic        saturated;

    modport source (output valid, output normal_out, output saturated, input ready);
    modport sink   (input valid, input normal_out, input saturated, output ready);
endinterface

`default_nettype wire

>>> rtl/inverse_normal_cdf_approx.sv
// Channel  | Dir | Payload                          | Handshake
// i_in     | in  | uniform_in[31:0] unsigned Q0.32  | valid/ready
// o_out    | out | normal_out[31:0] signed Q5.27,  | valid/ready
//          |     | saturated                        |
// One beat per cycle while the output is not stalled.
// Latency is set by the tail: two 30-stage log2 pipelines and eight Horner stages.
// The central rational and its 32-stage divider run alongside and are delayed to match.
// i_rst_n clears only valid bits; payload registers are not reset.
// A stalled output freezes the whole pipeline; ready is low only while it holds a beat.
`default_nettype none
`include "assert_macros.svh"

module inverse_normal_cdf_approx import icdf_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    icdf_in_if.sink    i_in,
    icdf_out_if.source o_out
);

    typedef struct packed {
        logic neg;
        logic sat;
        logic cen;
    } t_side;

    logic              w_adv;
    logic [PIPE_LAT:0] r_vld;
    logic [U_W-1:0]    r_u;
    t_side             r_side [1:PIPE_LAT];
    t_side             w_side;
    logic              w_upper;
    logic [U_W-1:0]    w_ax, w_ymass;
    logic [OUT_W-1:0]  w_cmag, w_tmag, w_mag, n_norm;
    logic              r_o_vld;
    logic [OUT_W-1:0]  r_o_norm;
    logic              r_o_sat;

    assign w_adv      = !r_o_vld || o_out.ready;
    assign i_in.ready = w_adv;

    assign w_upper = r_u[U_W-1];
    assign w_ax    = w_upper ? (r_u - U_HALF) : (U_HALF - r_u);
    assign w_ymass = w_upper ? (U_W'(0) - r_u) : r_u;

    assign w_side.neg = !w_upper;
    assign w_side.sat = (r_u == '0);
    assign w_side.cen = (w_ax < CENTRAL_LIMIT);

    icdf_central u_central (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_ax  (w_ax),
        .o_mag (w_cmag)
    );

    icdf_tail u_tail (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_ymass (w_ymass),
        .o_mag   (w_tmag)
    );

    assign w_mag = r_side[PIPE_LAT].cen ? w_cmag : w_tmag;

    always_comb begin
        if (r_side[PIPE_LAT].sat) begin
            n_norm = NORM_MIN;
        end else if (r_side[PIPE_LAT].neg) begin
            n_norm = OUT_W'(0) - w_mag;
        end else begin
            n_norm = w_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld   <= {r_vld[PIPE_LAT-1:0], i_in.valid};
            r_o_vld <= r_vld[PIPE_LAT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_u       <= i_in.uniform_in;
            r_side[1] <= w_side;
            for (int k = 2; k <= PIPE_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_o_norm  <= n_norm;
            r_o_sat   <= r_side[PIPE_LAT].sat;
        end
    end

    assign o_out.valid      = r_o_vld;
    assign o_out.normal_out = r_o_norm;
    assign o_out.saturated  = r_o_sat;

    `ICDF_ASSERT(a_sat_value,
        (o_out.valid && o_out.saturated) |-> (o_out.normal_out == NORM_MIN),
        "saturated beat without minimum value")
    `ICDF_ASSERT_NEXT(a_stall_hold, !w_adv, $stable(r_vld),
        "pipeline moved during output stall")
    `ICDF_ASSERT(a_out_rise, $rose(r_o_vld) |-> $past(r_vld[PIPE_LAT]),
        "output valid without a last-stage beat")
    `ICDF_ASSERT_NEXT(a_zero_flag, w_adv && r_vld[0] && (r_u == '0), r_side[1].sat,
        "zero sample not flagged")

endmodule

`default_nettype wire

>>> rtl/icdf_log2.sv
// Pipelined log2 in Q28: normalize, then one mantissa squaring per stage
`default_nettype none

module icdf_log2 import icdf_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [LOG_IN_W-1:0] i_m,
    output logic      [LOG_W-1:0]    o_log
);

    localparam int P_W  = 6;
    localparam int MN_W = 31;
    localparam int MSB  = MN_W - 1;

    logic [LOG_IN_W-1:0] r_m;
    logic [P_W-1:0]      r_p0;
    logic [P_W-1:0]      n_p0;
    logic [MN_W-1:0]     n_mn0;
    logic [P_W-1:0]      r_p  [0:Q_FRAC];
    logic [MN_W-1:0]     r_mn [0:Q_FRAC];
    logic [Q_FRAC-1:0]   r_f  [0:Q_FRAC];

    // msb index; zero input gives zero
    always_comb begin
        n_p0 = '0;
        for (int i = 1; i < LOG_IN_W; i++) begin
            if (i_m[i]) begin
                n_p0 = P_W'(i);
            end
        end
    end

    // mantissa to Q30 in [1,2)
    always_comb begin
        if (r_p0 >= P_W'(MSB)) begin
            n_mn0 = MN_W'(r_m >> (r_p0 - P_W'(MSB)));
        end else begin
            n_mn0 = MN_W'(r_m << (P_W'(MSB) - r_p0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m     <= i_m;
            r_p0    <= n_p0;
            r_mn[0] <= n_mn0;
            r_p[0]  <= r_p0;
            r_f[0]  <= '0;
        end
    end

    for (genvar j = 0; j < Q_FRAC; j++) begin : g_sq
        logic [2*MN_W-1:0] w_sq;
        logic [MN_W:0]     w_s;

        assign w_sq = r_mn[j] * r_mn[j];
        assign w_s  = w_sq[2*MN_W-1:MN_W-1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[j+1] <= r_p[j];
                if (w_s[MN_W]) begin
                    r_mn[j+1] <= w_s[MN_W:1];
                    r_f[j+1]  <= r_f[j] | (Q_FRAC'(1) << (Q_FRAC - 1 - j));
                end else begin
                    r_mn[j+1] <= w_s[MN_W-1:0];
                    r_f[j+1]  <= r_f[j];
                end
            end
        end
    end

    assign o_log = {r_p[Q_FRAC], r_f[Q_FRAC]};

endmodule

`default_nettype wire

>>> rtl/icdf_central.sv
// Central region: rational in x^2, restoring divider, delay to tail latency
`default_nettype none

module icdf_central import icdf_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [U_W-1:0]   i_ax,
    output logic      [OUT_W-1:0] o_mag
);

    localparam int Y_W   = 28;
    localparam int XQ_W  = 28;
    localparam int NUM_W = 64;
    localparam int DC_W  = POLY_W - 1;

    function automatic logic signed [POLY_W-1:0] hstep(
        input logic signed [POLY_W-1:0] a,
        input logic        [Y_W-1:0]    y,
        input logic signed [POLY_W-1:0] c
    );
        logic signed [POLY_W+Y_W:0] prod;
        prod = a * $signed({1'b0, y});
        return POLY_W'(prod >>> Q_FRAC) + c;
    endfunction

    logic [63:0]              w_sq;
    logic [Y_W-1:0]           r_y1, r_y2, r_y3, r_y4;
    logic [XQ_W-1:0]          r_xq1, r_xq2, r_xq3, r_xq4, r_xq5;
    logic signed [POLY_W-1:0] r_p2, r_p3, r_p4, r_d2, r_d3, r_d4, r_d5;
    logic [DC_W-1:0]          r_p5;
    logic [DC_W-1:0]          w_dc;
    logic [NUM_W-1:0]         w_num;

    logic [DEN_W-1:0]  r_rem [0:QUO_W];
    logic [DEN_W-1:0]  r_dv  [0:QUO_W];
    logic [QUO_W-1:0]  r_nl  [0:QUO_W];
    logic [QUO_W-1:0]  r_q   [0:QUO_W];
    logic [OUT_W-1:0]  r_mag;
    logic [OUT_W-1:0]  r_pad [0:CEN_PAD-1];

    assign w_sq = 64'(i_ax) * 64'(i_ax);

    // a zero or negative denominator is forced to one LSB
    assign w_dc  = (r_d5[POLY_W-1] || r_d5 == '0) ? DC_W'(1) : r_d5[DC_W-1:0];
    assign w_num = NUM_W'(r_xq5) * NUM_W'(r_p5) + NUM_W'(w_dc);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y1  <= w_sq[63:36];
            r_xq1 <= i_ax[U_W-1:4];

            r_p2  <= hstep(NUM_A[3], r_y1, NUM_A[2]);
            r_d2  <= hstep(DEN_B[3], r_y1, DEN_B[2]);
            r_y2  <= r_y1;
            r_xq2 <= r_xq1;

            r_p3  <= hstep(r_p2, r_y2, NUM_A[1]);
            r_d3  <= hstep(r_d2, r_y2, DEN_B[1]);
            r_y3  <= r_y2;
            r_xq3 <= r_xq2;

            r_p4  <= hstep(r_p3, r_y3, NUM_A[0]);
            r_d4  <= hstep(r_d3, r_y3, DEN_B[0]);
            r_y4  <= r_y3;
            r_xq4 <= r_xq3;

            r_p5  <= r_p4[POLY_W-1] ? '0 : r_p4[DC_W-1:0];
            r_d5  <= hstep(r_d4, r_y4, ONE_Q28);
            r_xq5 <= r_xq4;

            // quotient fits 32 bits, so the top half starts below the divisor
            r_rem[0] <= DEN_W'(w_num[NUM_W-1:QUO_W]);
            r_nl[0]  <= w_num[QUO_W-1:0];
            r_dv[0]  <= {w_dc, 1'b0};
            r_q[0]   <= '0;
        end
    end

    for (genvar i = 0; i < QUO_W; i++) begin : g_div
        logic [DEN_W:0] w_sh;
        logic [DEN_W:0] w_diff;

        assign w_sh   = {r_rem[i], r_nl[i][QUO_W-1-i]};
        assign w_diff = w_sh - {1'b0, r_dv[i]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[i+1] <= r_dv[i];
                r_nl[i+1] <= r_nl[i];
                if (!w_diff[DEN_W]) begin
                    r_rem[i+1] <= w_diff[DEN_W-1:0];
                    r_q[i+1]   <= {r_q[i][QUO_W-2:0], 1'b1};
                end else begin
                    r_rem[i+1] <= w_sh[DEN_W-1:0];
                    r_q[i+1]   <= {r_q[i][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag    <= r_q[QUO_W][QUO_W-1] ? MAG_MAX : r_q[QUO_W];
            r_pad[0] <= r_mag;
            for (int k = 1; k < CEN_PAD; k++) begin
                r_pad[k] <= r_pad[k-1];
            end
        end
    end

    assign o_mag = r_pad[CEN_PAD-1];

endmodule

`default_nettype wire

>>> rtl/icdf_tail.sv
// Tail region: two log2 pipelines, then Moro series in ln(-ln y)
`default_nettype none

module icdf_tail import icdf_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [U_W-1:0]   i_ymass,
    output logic      [OUT_W-1:0] o_mag
);

    logic [LOG_W-1:0]    w_la, w_lb;
    logic [LOG_W-1:0]    w_t, w_lg;
    logic [63:0]         w_prod_a, w_prod_b, w_lq, w_r;
    logic [LOG_IN_W-1:0] r_lq;
    logic [U_W-1:0]      r_rr  [0:TAIL_ORD-1];
    logic [ACC_W-1:0]    r_acc [1:TAIL_ORD];
    logic [ACC_W:0]      w_rnd;
    logic [OUT_W-1:0]    w_mag;
    logic [OUT_W-1:0]    r_mag;

    icdf_log2 u_log_a (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_m   (LOG_IN_W'(i_ymass)),
        .o_log (w_la)
    );

    // -ln y = (32 - log2 Y) * ln2
    assign w_t      = TAIL_T0 - w_la;
    assign w_prod_a = 64'(w_t) * 64'(LN2_Q30);
    assign w_lq     = (w_prod_a + RND_Q30) >> 30;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lq <= w_lq[LOG_IN_W-1:0];
        end
    end

    icdf_log2 u_log_b (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_m   (r_lq),
        .o_log (w_lb)
    );

    assign w_lg     = w_lb - LG_OFF;
    assign w_prod_b = 64'(w_lg) * 64'(LN2_Q30);
    assign w_r      = (w_prod_b + RND_Q30) >> 30;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rr[0] <= w_r[U_W-1:0];
        end
    end

    // acc*r split at bit 32 keeps each product within 32 by 32
    for (genvar i = 0; i < TAIL_ORD; i++) begin : g_horn
        logic [ACC_W-1:0]   w_src;
        logic [ACC_W-1:0]   w_hi;
        logic [2*U_W-1:0]   w_lo;

        if (i == 0) begin : g_first
            assign w_src = TAIL_C[TAIL_ORD];
        end else begin : g_rest
            assign w_src = r_acc[i];
        end

        assign w_hi = ACC_W'(w_src[ACC_W-1:U_W]) * ACC_W'(r_rr[i]);
        assign w_lo = 64'(w_src[U_W-1:0]) * 64'(r_rr[i]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[i+1] <= ACC_W'({w_hi, 4'b0000}) + ACC_W'(w_lo >> Q_FRAC)
                              + TAIL_C[TAIL_ORD-1-i];
            end
        end

        if (i < TAIL_ORD - 1) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rr[i+1] <= r_rr[i];
                end
            end
        end
    end

    // Q32 to Q27, round half up
    assign w_rnd = (ACC_W+1)'(r_acc[TAIL_ORD]) + (ACC_W+1)'(16);
    assign w_mag = w_rnd[ACC_W:5];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= w_mag[OUT_W-1] ? MAG_MAX : w_mag;
        end
    end

    assign o_mag = r_mag;

endmodule

`default_nettype wire

>>> tb/tb_inverse_normal_cdf_approx.sv
// Testbench for inverse_normal_cdf_approx: directed table, biased random samples, bit-exact predictor
`timescale 1ns / 1ps
`default_nettype none

module tb_inverse_normal_cdf_approx;
    import icdf_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] normal_out;
        logic             saturated;
    } t_deviate;

    typedef struct {
        logic [U_W-1:0] u;
        bit             typed;
        t_deviate       dev;
    } t_stim_row;

    localparam longint unsigned BOUNDARY = 64'd1803886265;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 150;
    localparam int HOLD_CYCLES    = 500;
    localparam int N_RANDOM       = 1380;

    logic i_clk;
    logic i_rst_n;

    icdf_in_if  in_ch ();
    icdf_out_if out_ch ();

    inverse_normal_cdf_approx dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    longint    num_q [4];
    longint    den_q [4];
    longint unsigned tail_q [9];
    t_deviate  pending_devs [$];
    int        n_errors   = 0;
    int        n_results  = 0;
    int        n_central  = 0;
    int        n_tail     = 0;
    int        n_sat      = 0;
    int        idle_count = 0;
    bit        rx_holding = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint to_q28(longint unsigned n);
        return longint'((n * 64'd131072 + 64'd24414062) / 64'd48828125);
    endfunction

    function automatic longint unsigned to_q32(longint unsigned n);
        return (n * 64'd1048576 + 64'd122070312) / 64'd244140625;
    endfunction

    // msb index plus 28 fraction bits by squaring a Q30 mantissa
    function automatic longint unsigned log2_fix(longint unsigned m);
        int unsigned pos;
        longint unsigned mn;
        longint unsigned frac;
        pos = 0;
        frac = 0;
        while (pos < 63 && (m >> (pos + 1)) != 0)
            pos++;
        mn = (pos >= 30) ? (m >> (pos - 30)) : (m << (30 - pos));
        for (int k = 27; k >= 0; k--) begin
            mn = (mn * mn) >> 30;
            if (mn >= (64'd1 << 31)) begin
                mn = mn >> 1;
                frac |= 64'd1 << k;
            end
        end
        return (longint'(pos) << 28) | frac;
    endfunction

    function automatic t_deviate predict_deviate(logic [U_W-1:0] u_in);
        longint unsigned uu, ax, ymass, t, lq, lg, r, acc, mag;
        longint y, xq, p, d;
        logic [127:0] prod;
        bit upper;
        t_deviate res;
        uu = {32'd0, u_in};
        upper = uu >= (64'd1 << 31);
        ax = upper ? uu - (64'd1 << 31) : (64'd1 << 31) - uu;
        res.saturated = 1'b0;
        if (uu == 0) begin
            res.normal_out = NORM_MIN;
            res.saturated = 1'b1;
            return res;
        end
        if (ax < BOUNDARY) begin
            y = longint'((ax * ax) >> 36);
            xq = longint'(ax >> 4);
            p = num_q[3];
            d = den_q[3];
            for (int k = 2; k >= 0; k--)
                p = ((p * y) >>> 28) + num_q[k];
            for (int k = 2; k >= 0; k--)
                d = ((d * y) >>> 28) + den_q[k];
            d = ((d * y) >>> 28) + 64'sd268435456;
            if (p < 0) p = 0;
            if (d < 1) d = 1;
            mag = longint'((xq * p + d) / (2 * d));
        end else begin
            ymass = upper ? (64'd1 << 32) - uu : uu;
            t = (64'd32 << 28) - log2_fix(ymass);
            lq = (t * 64'd744261118 + (64'd1 << 29)) >> 30;
            lg = log2_fix(lq) - (64'd28 << 28);
            r = (lg * 64'd744261118 + (64'd1 << 29)) >> 30;
            acc = tail_q[8];
            for (int k = 7; k >= 0; k--) begin
                prod = {64'd0, acc} * {64'd0, r};
                acc = prod[91:28] + tail_q[k];
            end
            mag = (acc + 16) >> 5;
        end
        if (mag > 64'h7FFF_FFFF)
            mag = 64'h7FFF_FFFF;
        res.normal_out = upper ? mag[31:0] : 32'(-mag[31:0]);
        return res;
    endfunction

    // random sample, biased toward tails, the central boundary and the midpoint
    function automatic logic [U_W-1:0] pick_sample();
        longint unsigned off;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        off = BOUNDARY + $urandom_range(0, 2000) - 1000;
        case (sel)
            4: return $urandom >> $urandom_range(0, 31);
            5: return 32'hFFFF_FFFF - ($urandom >> $urandom_range(0, 31));
            6: return 32'(64'h8000_0000 + off);
            7: return 32'(64'h8000_0000 - off);
            8: return 32'h8000_0000 + $urandom_range(0, 4000) - 2000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(logic [U_W-1:0] u, bit typed, t_deviate dev, int gap);
        longint unsigned ax;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.uniform_in <= u;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_devs.push_back(typed ? dev : predict_deviate(u));
        ax = (u >= U_HALF) ? u - 64'h8000_0000 : 64'h8000_0000 - u;
        if (u == 0) n_sat++;
        else if (ax < BOUNDARY) n_central++;
        else n_tail++;
    endtask

    // stimulus
    initial begin
        t_stim_row rows [$];
        t_deviate none_dev;
        int gap_mode;
        int gap;
        none_dev = '0;
        for (int k = 0; k < 4; k++) begin
            num_q[k] = to_q28(k == 0 ? 64'd250662823884 : k == 1 ? 64'd1861500062529 :
                              k == 2 ? 64'd4139119773534 : 64'd2544106049637);
            den_q[k] = to_q28(k == 0 ? 64'd847351093090 : k == 1 ? 64'd2308336743743 :
                              k == 2 ? 64'd2106224101826 : 64'd313082909833);
        end
        num_q[1] = -num_q[1]; num_q[3] = -num_q[3];
        den_q[0] = -den_q[0]; den_q[2] = -den_q[2];
        tail_q = '{to_q32(64'd337475482273), to_q32(64'd976169019092),
                   to_q32(64'd160797971492), to_q32(64'd27643881033),
                   to_q32(64'd3840572937), to_q32(64'd395189651),
                   to_q32(64'd32176788), to_q32(64'd288817), to_q32(64'd396032)};

        rows = '{
            '{32'h0000_0000, 1, '{NORM_MIN, 1'b1}},   // zero input saturates
            '{32'h8000_0000, 1, '{32'h0, 1'b0}},      // exact midpoint
            '{32'h0000_0001, 0, none_dev},
            '{32'hFFFF_FFFF, 0, none_dev},
            '{32'h0000_0002, 0, none_dev},
            '{32'hFFFF_FFFE, 0, none_dev},
            '{32'h7FFF_FFFF, 0, none_dev},
            '{32'h8000_0001, 0, none_dev},
            '{32'(64'h8000_0000 + BOUNDARY - 1), 0, none_dev},
            '{32'(64'h8000_0000 + BOUNDARY), 0, none_dev},
            '{32'(64'h8000_0000 - BOUNDARY + 1), 0, none_dev},
            '{32'(64'h8000_0000 - BOUNDARY), 0, none_dev},
            '{32'h5555_5555, 0, none_dev},
            '{32'hAAAA_AAAA, 0, none_dev},
            '{32'h0000_8000, 0, none_dev},
            '{32'hFFFF_0000, 0, none_dev},
            '{32'h1000_0000, 0, none_dev},
            '{32'hC000_0000, 0, none_dev}
        };

        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.uniform_in <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            send_beat(rows[i].u, rows[i].typed, rows[i].dev, $urandom_range(0, 3));

        gap_mode = 0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 100 == 0)
                gap_mode = $urandom_range(0, 2);
            if (i == 700) begin
                // let the pipe drain fully before going on
                in_ch.valid <= 1'b0;
                wait (pending_devs.size() == 0);
                @(posedge i_clk);
            end
            if (rx_holding || gap_mode == 0) gap = 0;
            else if (gap_mode == 1) gap = $urandom_range(0, 18);
            else gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
            send_beat(pick_sample(), 0, none_dev, gap);
        end
        in_ch.valid <= 1'b0;

        wait (pending_devs.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d central, %0d tail and %0d zero samples; %0d results checked.",
                 n_central, n_tail, n_sat, n_results);
        $display("Output stalls included a %0d-cycle hold with the input backed up.",
                 HOLD_CYCLES);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // result receiver
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (n_results == 300 && !rx_holding) begin
                rx_holding = 1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_holding = 0;
            end else begin
                stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
                if (stall > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_deviate want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_results <= n_results + 1;
            if (pending_devs.size() == 0) begin
                $display("%0t: unexpected beat normal_out=%h saturated=%b", $time,
                         out_ch.normal_out, out_ch.saturated);
                n_errors++;
            end else begin
                want = pending_devs.pop_front();
                if (out_ch.normal_out !== want.normal_out) begin
                    $display("%0t: normal_out expected %h actual %h", $time,
                             want.normal_out, out_ch.normal_out);
                    n_errors++;
                end
                if (out_ch.saturated !== want.saturated) begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             want.saturated, out_ch.saturated);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
            if (idle_count >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, %0d results outstanding", $time,
                         pending_devs.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
